@@ rtl/vang_pkg.sv @@
// Shared constants, types and elaboration-time angle tables for the vector angle pipeline.
package vang_pkg;

	localparam int COORD_BITS_DEF      = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 13;
	localparam int CORDIC_STAGES_DEF   = 16;
	localparam int GUARD_BITS          = 6;
	localparam int OUT_BITS            = 16;
	localparam int NORM_MSB            = 58;
	localparam int XY_BITS             = 62;
	localparam int SH_BITS             = 6;

	typedef struct packed {
		logic dx_zero;
		logic dy_zero;
		logic dx_neg;
		logic dy_neg;
	} quad_t;

	function automatic logic [63:0] atan_pow2_q62(input int i);
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] term;
		int k;
		p = 64'd1 << (62 - i);
		sum = 64'd0;
		k = 0;
		while (p != 64'd0) begin
			term = p / 64'(2 * k + 1);
			if ((k % 2) == 0) begin
				sum = sum + term;
			end else begin
				sum = sum - term;
			end
			p = p >> (2 * i);
			k++;
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_recip5_q62();
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] term;
		int k;
		p = (64'd1 << 62) / 5;
		sum = 64'd0;
		k = 0;
		while (p != 64'd0) begin
			term = p / 64'(2 * k + 1);
			if ((k % 2) == 0) begin
				sum = sum + term;
			end else begin
				sum = sum - term;
			end
			p = p / 25;
			k++;
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_recip239_q62();
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] term;
		int k;
		p = (64'd1 << 62) / 239;
		sum = 64'd0;
		k = 0;
		while (p != 64'd0) begin
			term = p / 64'(2 * k + 1);
			if ((k % 2) == 0) begin
				sum = sum + term;
			end else begin
				sum = sum - term;
			end
			p = p / 57121;
			k++;
		end
		return sum;
	endfunction

	function automatic logic [63:0] quarter_pi_q62();
		return 64'd4 * atan_recip5_q62() - atan_recip239_q62();
	endfunction

	function automatic logic [63:0] round_q62(input logic [63:0] v, input int drop);
		return (v + (64'd1 << (drop - 1))) >> drop;
	endfunction

	function automatic logic [63:0] stage_angle(input int i, input int work_frac);
		logic [63:0] a;
		a = (i == 0) ? quarter_pi_q62() : atan_pow2_q62(i);
		return round_q62(a, 62 - work_frac);
	endfunction

endpackage

@@ rtl/vang_point_if.sv @@
// Input channel carrying one origin point and one target point per beat.
interface vang_point_if import vang_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] origin_x;
	logic signed [COORD_BITS-1:0] origin_y;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;

	modport source(output valid, output origin_x, output origin_y, output point_x,
		output point_y, input ready);
	modport sink(input valid, input origin_x, input origin_y, input point_x,
		input point_y, output ready);
endinterface

@@ rtl/vang_angle_if.sv @@
// Output channel carrying one angle per beat.
interface vang_angle_if import vang_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] angle;

	modport source(output valid, output angle, input ready);
	modport sink(input valid, input angle, output ready);
endinterface

@@ rtl/vector_angle_atan2.sv @@
// The pipeline has four front stages, one stage per CORDIC micro-rotation, and two back stages.
// Throughput is one beat per cycle; the whole pipeline advances when the output is free.
// A stalled output holds every stage in place, so no beat is lost or repeated.
// The asynchronous reset clears all valid bits; the data registers are not reset.
module vector_angle_atan2 import vang_pkg::*; #(
	parameter int COORD_BITS      = COORD_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	vang_point_if.sink   vec,
	vang_angle_if.source res
);
	localparam int WORK_FRAC = ANGLE_FRAC_BITS + GUARD_BITS;
	localparam int ZW        = WORK_FRAC + 3;
	localparam logic [63:0] HALF_PI_64 = round_q62(quarter_pi_q62(), 61 - WORK_FRAC);
	localparam logic [63:0] PI_64      = round_q62(quarter_pi_q62(), 60 - WORK_FRAC);

	logic en;

	logic                      v_c [0:CORDIC_STAGES];
	logic signed [XY_BITS-1:0] x_c [0:CORDIC_STAGES];
	logic signed [XY_BITS-1:0] y_c [0:CORDIC_STAGES];
	logic signed [ZW-1:0]      z_c [0:CORDIC_STAGES];
	quad_t                     q_c [0:CORDIC_STAGES];

	assign en        = !res.valid || res.ready;
	assign vec.ready = en;
	assign z_c[0]    = '0;

	vang_prep #(
		.COORD_BITS(COORD_BITS)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_i      (vec.valid),
		.origin_x (vec.origin_x),
		.origin_y (vec.origin_y),
		.point_x  (vec.point_x),
		.point_y  (vec.point_y),
		.v_o      (v_c[0]),
		.x_o      (x_c[0]),
		.y_o      (y_c[0]),
		.q_o      (q_c[0])
	);

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic [63:0] ANG_64 = stage_angle(i, WORK_FRAC);

		vang_cordic_stage #(
			.ZW    (ZW),
			.SHIFT (i),
			.ANGLE (ZW'(ANG_64))
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (v_c[i]),
			.x_i    (x_c[i]),
			.y_i    (y_c[i]),
			.z_i    (z_c[i]),
			.q_i    (q_c[i]),
			.v_o    (v_c[i+1]),
			.x_o    (x_c[i+1]),
			.y_o    (y_c[i+1]),
			.z_o    (z_c[i+1]),
			.q_o    (q_c[i+1])
		);
	end

	vang_post #(
		.ZW      (ZW),
		.HALF_PI (ZW'(HALF_PI_64)),
		.PI      (ZW'(PI_64))
	) u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_i     (v_c[CORDIC_STAGES]),
		.z_i     (z_c[CORDIC_STAGES]),
		.q_i     (q_c[CORDIC_STAGES]),
		.v_o     (res.valid),
		.angle_o (res.angle)
	);
endmodule

@@ rtl/vang_prep.sv @@
// Front stages: coordinate differences, magnitudes and quadrant flags, leading-one search and normalizing shift.
module vang_prep import vang_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_i,
	input  logic signed [COORD_BITS-1:0] origin_x,
	input  logic signed [COORD_BITS-1:0] origin_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                       v_o,
	output logic signed [XY_BITS-1:0]  x_o,
	output logic signed [XY_BITS-1:0]  y_o,
	output quad_t                      q_o
);
	localparam int DW = COORD_BITS + 1;

	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [DW-1:0]        ax_s2, ay_s2, big_s2;
	logic [DW-1:0]        ax_s3, ay_s3;
	logic [SH_BITS-1:0]   sh_s3;
	quad_t                q_s2, q_s3, q_s4;
	logic signed [XY_BITS-1:0] x_s4, y_s4;

	logic [DW-1:0]      ax_c, ay_c;
	logic [SH_BITS-1:0] msb_c;
	quad_t              q_c;

	always_comb begin
		ax_c = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		ay_c = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
		q_c.dx_zero = (dx_s1 == '0);
		q_c.dy_zero = (dy_s1 == '0);
		q_c.dx_neg  = dx_s1[DW-1];
		q_c.dy_neg  = dy_s1[DW-1];
	end

	always_comb begin
		msb_c = '0;
		for (int b = 0; b < DW; b++) begin
			if (big_s2[b]) begin
				msb_c = SH_BITS'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= DW'(point_x) - DW'(origin_x);
			dy_s1  <= DW'(point_y) - DW'(origin_y);
			ax_s2  <= ax_c;
			ay_s2  <= ay_c;
			big_s2 <= (ax_c > ay_c) ? ax_c : ay_c;
			q_s2   <= q_c;
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			sh_s3  <= SH_BITS'(NORM_MSB) - msb_c;
			q_s3   <= q_s2;
			x_s4   <= $signed(XY_BITS'(ax_s3) << sh_s3);
			y_s4   <= $signed(XY_BITS'(ay_s3) << sh_s3);
			q_s4   <= q_s3;
		end
	end

	assign v_o = v_s4;
	assign x_o = x_s4;
	assign y_o = y_s4;
	assign q_o = q_s4;
endmodule

@@ rtl/vang_cordic_stage.sv @@
// One registered CORDIC vectoring micro-rotation.
module vang_cordic_stage import vang_pkg::*; #(
	parameter int              ZW    = ANGLE_FRAC_BITS_DEF + GUARD_BITS + 3,
	parameter int              SHIFT = 0,
	parameter logic [ZW-1:0]   ANGLE = '0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      v_i,
	input  logic signed [XY_BITS-1:0] x_i,
	input  logic signed [XY_BITS-1:0] y_i,
	input  logic signed [ZW-1:0]      z_i,
	input  quad_t                     q_i,
	output logic                      v_o,
	output logic signed [XY_BITS-1:0] x_o,
	output logic signed [XY_BITS-1:0] y_o,
	output logic signed [ZW-1:0]      z_o,
	output quad_t                     q_o
);
	logic                      v_s1;
	logic signed [XY_BITS-1:0] x_s1, y_s1;
	logic signed [ZW-1:0]      z_s1;
	quad_t                     q_s1;
	logic signed [XY_BITS-1:0] xs, ys;

	assign xs = x_i >>> SHIFT;
	assign ys = y_i >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_i[XY_BITS-1]) begin
				x_s1 <= x_i + ys;
				y_s1 <= y_i - xs;
				z_s1 <= z_i + $signed(ANGLE);
			end else begin
				x_s1 <= x_i - ys;
				y_s1 <= y_i + xs;
				z_s1 <= z_i - $signed(ANGLE);
			end
			q_s1 <= q_i;
		end
	end

	assign v_o = v_s1;
	assign x_o = x_s1;
	assign y_o = y_s1;
	assign z_o = z_s1;
	assign q_o = q_s1;
endmodule

@@ rtl/vang_post.sv @@
// Back stages: clamp, quadrant fold with special cases, and rounding to the output format.
module vang_post import vang_pkg::*; #(
	parameter int            ZW      = ANGLE_FRAC_BITS_DEF + GUARD_BITS + 3,
	parameter logic [ZW-1:0] HALF_PI = '0,
	parameter logic [ZW-1:0] PI      = '0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       v_i,
	input  logic signed [ZW-1:0]       z_i,
	input  quad_t                      q_i,
	output logic                       v_o,
	output logic signed [OUT_BITS-1:0] angle_o
);
	localparam int RW = ZW - GUARD_BITS;
	localparam logic signed [ZW-1:0] RND = ZW'(64'd1 << (GUARD_BITS - 1));

	logic                       v_s1, v_s2;
	logic signed [ZW-1:0]       z_s1;
	logic signed [OUT_BITS-1:0] angle_s2;

	logic signed [ZW-1:0]          a_c, f_c, sum_c;
	logic signed [RW-1:0]          r_c;
	logic signed [RW+OUT_BITS-1:0] rx_c;

	always_comb begin
		a_c = z_i;
		if (z_i < 0) begin
			a_c = '0;
		end else if (z_i > $signed(HALF_PI)) begin
			a_c = $signed(HALF_PI);
		end
		if (q_i.dx_zero) begin
			if (q_i.dy_zero) begin
				f_c = '0;
			end else if (q_i.dy_neg) begin
				f_c = -$signed(HALF_PI);
			end else begin
				f_c = $signed(HALF_PI);
			end
		end else if (q_i.dy_zero) begin
			f_c = q_i.dx_neg ? $signed(PI) : '0;
		end else begin
			f_c = q_i.dx_neg ? ($signed(PI) - a_c) : a_c;
			if (q_i.dy_neg) begin
				f_c = -f_c;
			end
		end
	end

	always_comb begin
		sum_c = z_s1 + RND;
		r_c   = $signed(sum_c[ZW-1:GUARD_BITS]);
		rx_c  = (RW + OUT_BITS)'(r_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1     <= f_c;
			angle_s2 <= rx_c[OUT_BITS-1:0];
		end
	end

	assign v_o     = v_s2;
	assign angle_o = angle_s2;
endmodule

@@ tb/vang_angle_checker.sv @@
// Checker that predicts each vector angle and compares it against the output channel.
module vang_angle_checker import vang_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	vang_point_if vec,
	vang_angle_if res,
	output int    mismatches,
	output int    outstanding,
	output int    results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WFRAC  = ANGLE_FRAC_BITS_DEF + GUARD_BITS;
	localparam int STAGES = CORDIC_STAGES_DEF;

	typedef logic signed [COORD_BITS_DEF-1:0] coord_t;
	typedef logic signed [OUT_BITS-1:0]       angle_t;

	longint rot_tbl [STAGES];
	longint half_pi_fx;
	longint pi_fx;
	angle_t angle_q [$];
	int     err_cnt  = 0;
	int     seen_cnt = 0;
	int     queued   = 0;

	assign mismatches   = err_cnt;
	assign outstanding  = queued;
	assign results_seen = seen_cnt;

	function automatic longint unsigned atan_series(input longint unsigned p0,
		input longint unsigned div);
		longint unsigned p;
		longint unsigned acc;
		longint unsigned term;
		longint unsigned k;
		p = p0;
		acc = 0;
		k = 0;
		while (p != 0) begin
			term = p / (2 * k + 1);
			if (k[0] == 1'b0) begin
				acc = acc + term;
			end else begin
				acc = acc - term;
			end
			p = p / div;
			k++;
		end
		return acc;
	endfunction

	function automatic longint unsigned round_drop(input longint unsigned v, input int drop);
		return (v + (64'd1 << (drop - 1))) >> drop;
	endfunction

	initial begin
		longint unsigned quarter;
		quarter = 4 * atan_series((64'd1 << 62) / 5, 25) - atan_series((64'd1 << 62) / 239, 57121);
		rot_tbl[0] = longint'(round_drop(quarter, 62 - WFRAC));
		for (int i = 1; i < STAGES; i++) begin
			rot_tbl[i] = longint'(round_drop(atan_series(64'd1 << (62 - i), 64'd1 << (2 * i)),
				62 - WFRAC));
		end
		half_pi_fx = longint'(round_drop(quarter, 61 - WFRAC));
		pi_fx = longint'(round_drop(quarter, 60 - WFRAC));
	end

	function automatic angle_t atan2_q13(input coord_t ox, input coord_t oy, input coord_t px,
		input coord_t py);
		longint dx;
		longint dy;
		longint ax;
		longint ay;
		longint big;
		longint x;
		longint y;
		longint xs;
		longint ys;
		longint z;
		longint r;
		dx = longint'(px) - longint'(ox);
		dy = longint'(py) - longint'(oy);
		if (dx == 0) begin
			z = (dy > 0) ? half_pi_fx : (dy < 0) ? -half_pi_fx : 0;
		end else if (dy == 0) begin
			z = (dx > 0) ? 0 : pi_fx;
		end else begin
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			big = (ax > ay) ? ax : ay;
			while (big < (64'sd1 <<< 58)) begin
				big = big <<< 1;
				ax = ax <<< 1;
				ay = ay <<< 1;
			end
			x = ax;
			y = ay;
			z = 0;
			for (int i = 0; i < STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + rot_tbl[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - rot_tbl[i];
				end
			end
			if (z < 0) z = 0;
			if (z > half_pi_fx) z = half_pi_fx;
			if (dx < 0) z = pi_fx - z;
			if (dy < 0) z = -z;
		end
		r = (z + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
		return r[OUT_BITS-1:0];
	endfunction

	always @(posedge clk) begin
		angle_t want;
		if (arst_n) begin
			if (vec.valid && vec.ready) begin
				angle_q.push_back(atan2_q13(vec.origin_x, vec.origin_y, vec.point_x, vec.point_y));
			end
			if (res.valid && res.ready) begin
				seen_cnt <= seen_cnt + 1;
				if (angle_q.size() == 0) begin
					$error("angle: expected no beat, got %0d", res.angle);
					err_cnt <= err_cnt + 1;
				end else begin
					want = angle_q.pop_front();
					if (res.angle !== want) begin
						$error("angle: expected %0d, got %0d", want, res.angle);
						err_cnt <= err_cnt + 1;
					end
				end
			end
			queued <= angle_q.size();
		end
	end

endmodule

@@ tb/tb_vector_angle_atan2.sv @@
// Top-level testbench that drives point pairs into the vector angle pipeline and gives the verdict.
module tb_vector_angle_atan2 import vang_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

	localparam int RANDOM_VECS = 1850;
	localparam int LONG_HOLD   = 200;
	localparam int DRAIN_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;
	bit   steady  = 1'b0;
	bit   holding = 1'b0;
	int   sent    = 0;
	int   mismatches;
	int   outstanding;
	int   results_seen;

	vang_point_if vec_if ();
	vang_angle_if res_if ();

	vector_angle_atan2 u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.vec   (vec_if),
		.res   (res_if)
	);

	vang_angle_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.vec         (vec_if),
		.res         (res_if),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.results_seen(results_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic coord_t corner_val();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return -1;
			2: return 0;
			3: return 1;
			default: return 32767;
		endcase
	endfunction

	task automatic send_vec(input coord_t ox, input coord_t oy, input coord_t px,
		input coord_t py);
		int gap;
		gap = (steady || holding) ? 0 : idle_len();
		if (gap > 0) begin
			vec_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vec_if.valid    <= 1'b1;
		vec_if.origin_x <= ox;
		vec_if.origin_y <= oy;
		vec_if.point_x  <= px;
		vec_if.point_y  <= py;
		@(posedge clk);
		while (!vec_if.ready) @(posedge clk);
		sent++;
	endtask

	initial begin : result_sink
		int stall;
		int run;
		int holds_done;
		res_if.ready = 1'b0;
		holds_done = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (holds_done < 2 && results_seen >= 300 + 600 * holds_done) begin
				holding = 1'b1;
				res_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holding = 1'b0;
				holds_done++;
			end else if (!steady) begin
				stall = idle_len();
				if (stall > 0) begin
					res_if.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			res_if.ready <= 1'b1;
			run = steady ? 1 : $urandom_range(1, 12);
			repeat (run) @(posedge clk);
		end
	end

	initial begin : stimulus
		coord_t ox;
		coord_t oy;
		coord_t px;
		coord_t py;
		int     mode;
		int     d;
		int     cyc;
		arst_n = 1'b0;
		vec_if.valid    = 1'b0;
		vec_if.origin_x = '0;
		vec_if.origin_y = '0;
		vec_if.point_x  = '0;
		vec_if.point_y  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_vec(0, 0, 0, 0);
		send_vec(1234, -567, 1234, -567);
		send_vec(0, 0, 100, 0);
		send_vec(0, 0, -100, 0);
		send_vec(0, 0, 0, 77);
		send_vec(0, 0, 0, -77);
		send_vec(-32768, -32768, 32767, 32767);
		send_vec(32767, 32767, -32768, -32768);
		send_vec(32767, -32768, -32768, 32767);
		send_vec(-32768, 32767, 32767, -32768);
		send_vec(-32768, 0, 32767, 0);
		send_vec(32767, 0, -32768, 0);
		send_vec(0, -32768, 0, 32767);
		send_vec(0, 32767, 0, -32768);
		send_vec(0, 0, 1, 32767);
		send_vec(0, 0, 32767, 1);
		send_vec(0, 0, -32768, -1);
		send_vec(0, 0, -32768, 1);
		send_vec(0, 0, 1, -1);
		send_vec(0, 0, -1, -1);
		send_vec(5, 5, 4, 5);
		send_vec(0, 0, 3, 4);
		send_vec(-1, -1, -1, -1);
		send_vec(0, 0, -3, 4);
		send_vec(0, 0, 3, -4);

		for (int n = 0; n < RANDOM_VECS; n++) begin
			steady = (n >= 800 && n < 1000);
			mode = $urandom_range(0, 99);
			ox = coord_t'($urandom);
			oy = coord_t'($urandom);
			px = coord_t'($urandom);
			py = coord_t'($urandom);
			if (mode < 40) begin
			end else if (mode < 60) begin
				ox = coord_t'(int'($urandom_range(0, 60000)) - 30000);
				oy = coord_t'(int'($urandom_range(0, 60000)) - 30000);
				px = coord_t'(int'(ox) + int'($urandom_range(0, 64)) - 32);
				py = coord_t'(int'(oy) + int'($urandom_range(0, 64)) - 32);
			end else if (mode < 72) begin
				if ($urandom_range(0, 1) == 0) px = ox;
				else py = oy;
			end else if (mode < 82) begin
				ox = coord_t'(int'($urandom_range(0, 32767)) - 16384);
				oy = coord_t'(int'($urandom_range(0, 32767)) - 16384);
				d = $urandom_range(1, 16383);
				px = coord_t'(($urandom_range(0, 1) == 0) ? int'(ox) + d : int'(ox) - d);
				py = coord_t'(($urandom_range(0, 1) == 0) ? int'(oy) + d : int'(oy) - d);
			end else begin
				ox = corner_val();
				oy = corner_val();
				px = corner_val();
				py = corner_val();
			end
			send_vec(ox, oy, px, py);
		end
		steady = 1'b0;
		vec_if.valid <= 1'b0;

		cyc = 0;
		while (results_seen < sent && cyc < DRAIN_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		repeat (40) @(posedge clk);
		$display("Sent %0d vectors and checked %0d angle beats, covering axes, coincident points,",
			sent, results_seen);
		$display("full-range differences, diagonals, random gaps and long output stalls.");
		if (cyc < DRAIN_LIMIT && mismatches == 0 && outstanding == 0 && results_seen == sent) begin
			$display("vector_angle_atan2: match");
		end else begin
			$display("vector_angle_atan2: mismatch");
		end
		$finish;
	end

	initial begin : watchdog
		#8000000;
		$display("vector_angle_atan2: mismatch");
		$finish;
	end

endmodule
